FILE: src/jtts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtts_pkg
// Shared types and constants of the joint trajectory time scaling unit.
// ----------------------------------------------------------------------------
package jtts_pkg;

    localparam int ANGLE_W    = 16;
    localparam int IDX_W      = 6;
    localparam int MS_W       = 16;
    localparam int VEL_W      = 24;
    localparam int DUR_W      = 16;
    localparam int PC_W       = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // polynomial term widths (d <= 63)
    localparam int PNUM_W = 30;
    localparam int VNUM_W = 25;
    localparam int VDEN_W = 24;

    // divider sizing
    localparam int QUO_W      = (ANGLE_W > 24) ? ANGLE_W : 24;
    localparam int POS_NUM_W  = ANGLE_W + PNUM_W;
    localparam int POS_DEN_W  = PNUM_W;
    localparam int VEL_NUM_W  = ANGLE_W + VNUM_W + 10;
    localparam int VEL_DEN_W  = VDEN_W + DUR_W;
    localparam int VEL_CMP_W  = VEL_DEN_W + 24;
    localparam int ET_NUM_W   = QUO_W + IDX_W;
    localparam int ET_DEN_W   = IDX_W;

    localparam logic [9:0]       MS_PER_S    = 10'd1000;
    localparam logic [QUO_W:0]   VEL_SAT     = (QUO_W + 1)'(24'h800000);
    localparam logic [VEL_W-1:0] VEL_POS_MAX = 24'h7FFFFF;
    localparam logic [DUR_W-1:0] DUR_RESET   = 16'd1000;
    localparam logic [PC_W-1:0]  PC_RESET    = 7'd64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DURATION = 2'd0,
        CFG_POINTS   = 2'd1,
        CFG_PROFILE  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] start_angle;
        logic signed [ANGLE_W-1:0] end_angle;
    } traj_req_t;

    typedef struct packed {
        logic [IDX_W-1:0]          sample_index;
        logic [MS_W-1:0]           elapsed_ms;
        logic signed [ANGLE_W-1:0] angle;
        logic signed [VEL_W-1:0]   velocity;
        logic                      last;
    } traj_sample_t;

    // one sample on its way from the sequencer into the arithmetic
    typedef struct packed {
        logic                      valid;
        logic [IDX_W-1:0]          idx;
        logic [IDX_W-1:0]          d;
        logic                      last;
        logic signed [ANGLE_W-1:0] start_angle;
        logic [ANGLE_W-1:0]        mag;
        logic                      neg;
    } seq_item_t;

    // what rides beside the dividers
    typedef struct packed {
        logic                      valid;
        logic [IDX_W-1:0]          idx;
        logic                      last;
        logic signed [ANGLE_W-1:0] start_angle;
        logic                      neg;
        logic                      vel_ovf;
    } side_t;

endpackage

FILE: src/jtts_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtts_seq
// Takes a request and issues its sample indices, one per cycle.
// ----------------------------------------------------------------------------
module jtts_seq
    import jtts_pkg::*;
#(
    parameter int MAX_POINTS = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  traj_req_t         request,
    input  logic [PC_W-1:0]   point_count,
    output seq_item_t         item
);

    logic                      active_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic [IDX_W-1:0]          d_reg;
    logic signed [ANGLE_W-1:0] start_reg;
    logic [ANGLE_W-1:0]        mag_reg;
    logic                      neg_reg;

    logic                      accept;
    logic                      at_last;
    logic [PC_W-1:0]           n_clamp;
    logic signed [ANGLE_W:0]   delta;

    assign at_last = (idx_reg == d_reg);
    assign busy    = active_reg && !at_last;
    assign accept  = start && !busy;
    assign delta   = (ANGLE_W + 1)'(request.end_angle) - (ANGLE_W + 1)'(request.start_angle);

    always_comb
    begin
        if (point_count < PC_W'(2))
        begin
            n_clamp = PC_W'(2);
        end
        else if (point_count > PC_W'(MAX_POINTS))
        begin
            n_clamp = PC_W'(MAX_POINTS);
        end
        else
        begin
            n_clamp = point_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
            d_reg      <= '0;
        end
        else if (accept)
        begin
            active_reg <= 1'b1;
            idx_reg    <= '0;
            d_reg      <= IDX_W'(n_clamp - PC_W'(1));
        end
        else if (active_reg)
        begin
            if (at_last)
            begin
                active_reg <= 1'b0;
            end
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            start_reg <= request.start_angle;
            neg_reg   <= delta[ANGLE_W];
            mag_reg   <= delta[ANGLE_W] ? ANGLE_W'(-delta) : ANGLE_W'(delta);
        end
    end

    always_comb
    begin
        item.valid       = active_reg;
        item.idx         = idx_reg;
        item.d           = d_reg;
        item.last        = at_last;
        item.start_angle = start_reg;
        item.mag         = mag_reg;
        item.neg         = neg_reg;
    end

endmodule

FILE: src/jtts_poly.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtts_poly
// Six stage pipeline forming the numerators and denominators of the
// position, velocity and time ratios.
// ----------------------------------------------------------------------------
module jtts_poly
    import jtts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  seq_item_t            item,
    input  logic [DUR_W-1:0]     duration,
    input  logic                 quintic,
    output side_t                side,
    output logic [POS_NUM_W-1:0] pos_num,
    output logic [POS_DEN_W-1:0] pos_den,
    output logic [VEL_NUM_W-1:0] vel_num,
    output logic [VEL_DEN_W-1:0] vel_den,
    output logic [ET_NUM_W-1:0]  et_num,
    output logic [ET_DEN_W-1:0]  et_den
);

    localparam int VN_W = ANGLE_W + VNUM_W;

    seq_item_t it1_reg, it2_reg, it3_reg, it4_reg, it5_reg;
    side_t     side_reg;

    // stage 1
    logic [11:0] i2_1_reg, d2_1_reg, id_1_reg, ij_1_reg;
    // stage 2
    logic [11:0] i2_2_reg, d2_2_reg, ij_2_reg;
    logic [17:0] i3_2_reg, d3_2_reg;
    logic [23:0] d4_2_reg, ij2_2_reg;
    logic [16:0] pq_2_reg;
    logic [7:0]  c3_2_reg;
    // stage 3
    logic [PNUM_W-1:0] pnum_3_reg, pden_3_reg;
    logic [VNUM_W-1:0] vnum_3_reg;
    logic [VDEN_W-1:0] vden_3_reg;
    // stage 4
    logic [POS_NUM_W-1:0] posn_4_reg;
    logic [VN_W-1:0]      vn_4_reg;
    logic [VEL_DEN_W-1:0] vden_4_reg;
    logic [ET_NUM_W-1:0]  etn_4_reg;
    logic [PNUM_W-1:0]    pden_4_reg;
    // stage 5
    logic [POS_NUM_W-1:0] posn_5_reg;
    logic [VEL_NUM_W-1:0] veln_5_reg;
    logic [VEL_DEN_W-1:0] vden_5_reg;
    logic [ET_NUM_W-1:0]  etn_5_reg;
    logic [PNUM_W-1:0]    pden_5_reg;
    // stage 6
    logic [POS_NUM_W-1:0] posn_6_reg;
    logic [POS_DEN_W-1:0] pden_6_reg;
    logic [VEL_NUM_W-1:0] veln_6_reg;
    logic [VEL_DEN_W-1:0] vden_6_reg;
    logic [ET_NUM_W-1:0]  etn_6_reg;
    logic [ET_DEN_W-1:0]  etd_6_reg;

    logic [IDX_W-1:0] j1;
    logic [34:0]      pq_prod;
    logic [19:0]      pc_prod;
    logic             vel_ovf;

    assign j1      = item.d - item.idx;
    assign pq_prod = 35'(i3_2_reg) * 35'(pq_2_reg);
    assign pc_prod = 20'(i2_2_reg) * 20'(c3_2_reg);
    assign vel_ovf = VEL_CMP_W'(veln_5_reg) >= {vden_5_reg, 24'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            it1_reg  <= '0;
            it2_reg  <= '0;
            it3_reg  <= '0;
            it4_reg  <= '0;
            it5_reg  <= '0;
            side_reg <= '0;
        end
        else
        begin
            it1_reg <= item;
            it2_reg <= it1_reg;
            it3_reg <= it2_reg;
            it4_reg <= it3_reg;
            it5_reg <= it4_reg;
            side_reg.valid       <= it5_reg.valid;
            side_reg.idx         <= it5_reg.idx;
            side_reg.last        <= it5_reg.last;
            side_reg.start_angle <= it5_reg.start_angle;
            side_reg.neg         <= it5_reg.neg;
            side_reg.vel_ovf     <= vel_ovf;
        end
    end

    always_ff @(posedge clk)
    begin
        // stage 1: squares and cross terms
        i2_1_reg <= 12'(item.idx) * 12'(item.idx);
        d2_1_reg <= 12'(item.d) * 12'(item.d);
        id_1_reg <= 12'(item.idx) * 12'(item.d);
        ij_1_reg <= 12'(item.idx) * 12'(j1);

        // stage 2: cubes, fourth powers, inner polynomials
        i2_2_reg  <= i2_1_reg;
        d2_2_reg  <= d2_1_reg;
        ij_2_reg  <= ij_1_reg;
        i3_2_reg  <= 18'(i2_1_reg) * 18'(it1_reg.idx);
        d3_2_reg  <= 18'(d2_1_reg) * 18'(it1_reg.d);
        d4_2_reg  <= 24'(d2_1_reg) * 24'(d2_1_reg);
        ij2_2_reg <= 24'(ij_1_reg) * 24'(ij_1_reg);
        pq_2_reg  <= 17'(10) * 17'(d2_1_reg) + 17'(6) * 17'(i2_1_reg)
                     - 17'(15) * 17'(id_1_reg);
        c3_2_reg  <= 8'(3) * 8'(it1_reg.d) - 8'(2) * 8'(it1_reg.idx);

        // stage 3: profile terms
        if (quintic)
        begin
            pnum_3_reg <= PNUM_W'(pq_prod);
            pden_3_reg <= PNUM_W'(d4_2_reg) * PNUM_W'(it2_reg.d);
            vnum_3_reg <= VNUM_W'(30) * VNUM_W'(ij2_2_reg);
            vden_3_reg <= d4_2_reg;
        end
        else
        begin
            pnum_3_reg <= PNUM_W'(pc_prod);
            pden_3_reg <= PNUM_W'(d3_2_reg);
            vnum_3_reg <= VNUM_W'(6) * VNUM_W'(ij_2_reg);
            vden_3_reg <= VDEN_W'(d2_2_reg);
        end

        // stage 4: scale by angle span and duration
        posn_4_reg <= POS_NUM_W'(it3_reg.mag) * POS_NUM_W'(pnum_3_reg);
        vn_4_reg   <= VN_W'(it3_reg.mag) * VN_W'(vnum_3_reg);
        vden_4_reg <= VEL_DEN_W'(vden_3_reg) * VEL_DEN_W'(duration);
        etn_4_reg  <= ET_NUM_W'(it3_reg.idx) * ET_NUM_W'(duration);
        pden_4_reg <= pden_3_reg;

        // stage 5: ms to s
        posn_5_reg <= posn_4_reg;
        veln_5_reg <= VEL_NUM_W'(vn_4_reg) * VEL_NUM_W'(MS_PER_S);
        vden_5_reg <= vden_4_reg;
        etn_5_reg  <= etn_4_reg;
        pden_5_reg <= pden_4_reg;

        // stage 6: velocity overflow check, divider operands
        posn_6_reg <= posn_5_reg;
        pden_6_reg <= pden_5_reg;
        veln_6_reg <= vel_ovf ? '0 : veln_5_reg;
        vden_6_reg <= vden_5_reg;
        etn_6_reg  <= etn_5_reg;
        etd_6_reg  <= it5_reg.d;
    end

    assign side    = side_reg;
    assign pos_num = posn_6_reg;
    assign pos_den = pden_6_reg;
    assign vel_num = veln_6_reg;
    assign vel_den = vden_6_reg;
    assign et_num  = etn_6_reg;
    assign et_den  = etd_6_reg;

endmodule

FILE: src/jtts_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtts_div
// Pipelined restoring divider, one quotient bit per stage.
// Needs num < den << QW.
// ----------------------------------------------------------------------------
module jtts_div #(
    parameter int NW = 46,
    parameter int DW = 30,
    parameter int QW = 24
)
(
    input  logic          clk,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo,
    output logic [DW-1:0] rem,
    output logic [DW-1:0] den_out
);

    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] low_reg [QW];
    logic [QW-1:0] quo_reg [QW];
    logic [DW-1:0] den_reg [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [DW-1:0] rem_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] quo_in;
        logic [DW-1:0] den_in;
        logic [DW:0]   trial;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign rem_in = DW'(num[NW-1:QW]);
            assign low_in = num[QW-1:0];
            assign quo_in = '0;
            assign den_in = den;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign low_in = low_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign den_in = den_reg[k-1];
        end

        assign trial = {rem_in, low_in[QW-1]};
        assign ge    = trial >= {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= ge ? DW'(trial - {1'b0, den_in}) : DW'(trial);
            low_reg[k] <= low_in << 1;
            quo_reg[k] <= {quo_in[QW-2:0], ge};
            den_reg[k] <= den_in;
        end
    end

    assign quo     = quo_reg[QW-1];
    assign rem     = rem_reg[QW-1];
    assign den_out = den_reg[QW-1];

endmodule

FILE: src/joint_trajectory_time_scaling_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joint_trajectory_time_scaling_unit
// Expands a joint's start/end angle into a timed run of position and
// velocity samples along a cubic or quintic time scaling.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+-------------------------------
//  request   | start, busy (taken when    | request: start/end angle
//            | start && !busy)            |
//  sample    | sample_valid, one cycle    | sample: index, ms, angle,
//            |                            | velocity, last
//  config    | cfg_we                     | cfg_index, cfg_data
//
//  A request yields n samples (n = point_count clamped to 2..MAX_POINTS),
//  one per cycle, so a new request is taken only as a run's last sample
//  issues; busy drops during the last sample's issue cycle so runs follow
//  without a gap. The first sample of a run passes the sequencer register,
//  a six stage arithmetic pipeline, 24 one-bit divider stages and the
//  rounding/output register.
//  Reset loads the default configuration and empties the pipeline; the
//  sample side has no stall, every result is shown for a single cycle.
// ----------------------------------------------------------------------------
module joint_trajectory_time_scaling_unit
    import jtts_pkg::*;
#(
    parameter int MAX_POINTS = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  traj_req_t             request,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  sample_valid,
    output traj_sample_t          sample
);

    // configuration registers
    logic [DUR_W-1:0] duration_reg;
    logic [PC_W-1:0]  points_reg;
    logic             profile_reg;
    logic [DUR_W-1:0] duration_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duration_reg <= DUR_RESET;
            points_reg   <= PC_RESET;
            profile_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DURATION: duration_reg <= cfg_data;
                CFG_POINTS:   points_reg   <= PC_W'(cfg_data);
                CFG_PROFILE:  profile_reg  <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // zero duration behaves as 1 ms
    assign duration_eff = (duration_reg == '0) ? DUR_W'(1) : duration_reg;

    // sample sequencer
    seq_item_t item;

    jtts_seq #(
        .MAX_POINTS (MAX_POINTS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .point_count (points_reg),
        .item        (item)
    );

    // ratio operands
    side_t                side_p;
    logic [POS_NUM_W-1:0] pos_num;
    logic [POS_DEN_W-1:0] pos_den;
    logic [VEL_NUM_W-1:0] vel_num;
    logic [VEL_DEN_W-1:0] vel_den;
    logic [ET_NUM_W-1:0]  et_num;
    logic [ET_DEN_W-1:0]  et_den;

    jtts_poly u_poly (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .duration (duration_eff),
        .quintic  (profile_reg),
        .side     (side_p),
        .pos_num  (pos_num),
        .pos_den  (pos_den),
        .vel_num  (vel_num),
        .vel_den  (vel_den),
        .et_num   (et_num),
        .et_den   (et_den)
    );

    // three dividers of equal depth: position, velocity, elapsed time
    logic [QUO_W-1:0]     pos_q, vel_q, et_q;
    logic [POS_DEN_W-1:0] pos_r, pos_d;
    logic [VEL_DEN_W-1:0] vel_r, vel_d;
    logic [ET_DEN_W-1:0]  et_r, et_d;

    jtts_div #(.NW(POS_NUM_W), .DW(POS_DEN_W), .QW(QUO_W)) u_div_pos (
        .clk (clk), .num (pos_num), .den (pos_den),
        .quo (pos_q), .rem (pos_r), .den_out (pos_d)
    );

    jtts_div #(.NW(VEL_NUM_W), .DW(VEL_DEN_W), .QW(QUO_W)) u_div_vel (
        .clk (clk), .num (vel_num), .den (vel_den),
        .quo (vel_q), .rem (vel_r), .den_out (vel_d)
    );

    jtts_div #(.NW(ET_NUM_W), .DW(ET_DEN_W), .QW(QUO_W)) u_div_et (
        .clk (clk), .num (et_num), .den (et_den),
        .quo (et_q), .rem (et_r), .den_out (et_d)
    );

    // sideband delay matching the divider depth
    side_t side_reg [QUO_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QUO_W; k++)
            begin
                side_reg[k] <= '0;
            end
        end
        else
        begin
            side_reg[0] <= side_p;
            for (int k = 1; k < QUO_W; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // round to nearest, ties up: bump when 2*rem >= den
    side_t                     side_o;
    logic [QUO_W:0]            pos_mag, vel_mag, et_val, vel_lim;
    logic [ANGLE_W-1:0]        pos_mag_w;
    logic signed [ANGLE_W-1:0] angle_o;
    logic [VEL_W-1:0]          vel_o;
    logic                      sample_valid_reg;
    traj_sample_t              sample_reg;

    assign side_o  = side_reg[QUO_W-1];
    assign pos_mag = (QUO_W + 1)'(pos_q)
                     + (QUO_W + 1)'({pos_r, 1'b0} >= {1'b0, pos_d});
    assign vel_mag = (QUO_W + 1)'(vel_q)
                     + (QUO_W + 1)'({vel_r, 1'b0} >= {1'b0, vel_d});
    assign et_val  = (QUO_W + 1)'(et_q)
                     + (QUO_W + 1)'({et_r, 1'b0} >= {1'b0, et_d});

    assign pos_mag_w = ANGLE_W'(pos_mag);
    assign angle_o   = side_o.neg ? side_o.start_angle - $signed(pos_mag_w)
                                  : side_o.start_angle + $signed(pos_mag_w);

    // magnitude limited to 2^23; positive side trimmed to 2^23-1
    assign vel_lim = (side_o.vel_ovf || vel_mag >= VEL_SAT) ? VEL_SAT : vel_mag;

    always_comb
    begin
        if (side_o.neg)
        begin
            vel_o = VEL_W'(-vel_lim);
        end
        else if (vel_lim > (QUO_W + 1)'(VEL_POS_MAX))
        begin
            vel_o = VEL_POS_MAX;
        end
        else
        begin
            vel_o = VEL_W'(vel_lim);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid_reg <= 1'b0;
        end
        else
        begin
            sample_valid_reg <= side_o.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg.sample_index <= side_o.idx;
        sample_reg.elapsed_ms   <= MS_W'(et_val);
        sample_reg.angle        <= angle_o;
        sample_reg.velocity     <= $signed(vel_o);
        sample_reg.last         <= side_o.last;
    end

    assign sample_valid = sample_valid_reg;
    assign sample       = sample_reg;

endmodule

FILE: dv/tb_joint_trajectory_time_scaling_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_joint_trajectory_time_scaling_unit
// Self-checking bench for the joint trajectory time scaling unit. Requests
// are queued by a stimulus process and fed by a clocked driver with random
// gaps. Every taken request is expanded by a local predictor into its run of
// samples. A clocked monitor checks each sample strobe against the oldest
// predicted sample. Phases step through cubic and quintic profiles, short and
// long runs, and extreme durations.
// ----------------------------------------------------------------------------
module tb_joint_trajectory_time_scaling_unit;
    import jtts_pkg::*;

    localparam int                   MAX_PTS    = 64;
    localparam int                   CYCLE_CAP  = 600000;
    // Settle time after the last sample: pipeline depth plus margin.
    localparam int                   DRAIN_WAIT = 40;
    // Index 3 has no register behind it; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;
    localparam int                   PHASES     = 16;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  start        = 1'b0;
    logic                  busy;
    traj_req_t             request      = '0;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = CFG_DURATION;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  sample_valid;
    traj_sample_t          sample;

    // Local copy of the configuration, as the block should hold it.
    logic [DUR_W-1:0] dur_mirror     = DUR_RESET;
    logic [PC_W-1:0]  points_mirror  = PC_RESET;
    logic             quintic_mirror = 1'b0;

    traj_req_t    pending_requests[$];
    traj_sample_t expected_samples[$];
    int           mismatches = 0;
    int           cycles     = 0;
    int           gap_left   = 0;
    int           gap_next   = 0;
    bit           steady     = 1'b0;   // phase with no sender gaps

    joint_trajectory_time_scaling_unit #(.MAX_POINTS(MAX_PTS)) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample       (sample)
    );

    always #2 clk = ~clk;

    // round(q*k/den), ties up, clipped to cap
    function automatic longint unsigned ratio_round(longint unsigned q, longint unsigned k,
                                                    longint unsigned den,
                                                    longint unsigned cap);
        longint unsigned whole, rem, rk, res;
        whole = q / den;
        rem   = q % den;
        if (whole > cap)
            return cap;
        rk  = rem * k;
        res = whole * k + rk / den + (((rk % den) * 2 >= den) ? 1 : 0);
        return (res > cap) ? cap : res;
    endfunction

    // Expand one request into its samples under the mirrored configuration.
    function automatic void forecast_run(traj_req_t req);
        longint          s_ang, e_ang, delta, ang;
        longint unsigned mag, n, t, d, i, j, pnum, pden, vnum, vden, pmag, vmag;
        logic [VEL_W-1:0] vel;
        bit              neg;
        traj_sample_t    smp;
        s_ang = req.start_angle;
        e_ang = req.end_angle;
        delta = e_ang - s_ang;
        neg   = delta < 0;
        mag   = neg ? -delta : delta;
        n     = points_mirror;
        t     = (dur_mirror == 0) ? 1 : dur_mirror;
        if (n < 2)
            n = 2;
        if (n > MAX_PTS)
            n = MAX_PTS;
        d = n - 1;
        for (i = 0; i <= d; i++) begin
            j = d - i;
            if (quintic_mirror) begin
                pnum = i * i * i * (10 * d * d + 6 * i * i - 15 * i * d);
                pden = d * d * d * d * d;
                vnum = 30 * i * i * j * j;
                vden = d * d * d * d;
            end
            else begin
                pnum = i * i * (3 * d - 2 * i);
                pden = d * d * d;
                vnum = 6 * i * j;
                vden = d * d;
            end
            pmag = ratio_round(mag * pnum, 1, pden, 64'hFFFF_FFFF_FFFF_FFFF / 4);
            ang  = neg ? s_ang - longint'(pmag) : s_ang + longint'(pmag);
            vmag = ratio_round(mag * vnum, 1000, vden * t, 64'd8388608);
            if (neg)
                vel = VEL_W'(-vmag);
            else
                vel = (vmag > 64'd8388607) ? VEL_POS_MAX : VEL_W'(vmag);
            smp.sample_index = IDX_W'(i);
            smp.elapsed_ms   = MS_W'(ratio_round(i * t, 1, d, 64'hFFFF));
            smp.angle        = ANGLE_W'(ang);
            smp.velocity     = vel;
            smp.last         = (i == d);
            expected_samples.insert(expected_samples.size(), smp);
        end
    endfunction

    // Driver: holds start until taken, then idles the drawn gap.
    always @(posedge clk) begin
        if (rst_n) begin
            if (start && !busy) begin
                forecast_run(request);
                gap_left = gap_next;
            end
            if (start && busy) begin
                // still waiting for the block to take it
            end
            else if (gap_left > 0) begin
                gap_left = gap_left - 1;
                start <= 1'b0;
            end
            else if (pending_requests.size() > 0) begin
                request  <= pending_requests.pop_front();
                start    <= 1'b1;
                gap_next  = steady ? 0 : $urandom_range(0, 7);
            end
            else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: one sample per strobe, no back-pressure possible.
    always @(posedge clk) begin
        traj_sample_t want;
        if (rst_n && sample_valid) begin
            if (expected_samples.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected sample %p", $time, sample);
            end
            else begin
                want = expected_samples.pop_front();
                if (sample.sample_index !== want.sample_index) begin
                    mismatches++;
                    $display("%0t: sample_index exp %0d got %0d", $time,
                             want.sample_index, sample.sample_index);
                end
                if (sample.elapsed_ms !== want.elapsed_ms) begin
                    mismatches++;
                    $display("%0t: elapsed_ms exp %0d got %0d", $time,
                             want.elapsed_ms, sample.elapsed_ms);
                end
                if (sample.angle !== want.angle) begin
                    mismatches++;
                    $display("%0t: angle exp %0d got %0d", $time,
                             want.angle, sample.angle);
                end
                if (sample.velocity !== want.velocity) begin
                    mismatches++;
                    $display("%0t: velocity exp %0d got %0d", $time,
                             want.velocity, sample.velocity);
                end
                if (sample.last !== want.last) begin
                    mismatches++;
                    $display("%0t: last exp %0b got %0b", $time,
                             want.last, sample.last);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // One register write per edge; the enable is dropped by the caller.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_DURATION: dur_mirror     = val;
            CFG_POINTS:   points_mirror  = val[PC_W-1:0];
            CFG_PROFILE:  quintic_mirror = val[0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [15:0] dur, logic [15:0] pts, logic [15:0] prof);
        write_reg(CFG_DURATION, dur);
        write_reg(CFG_POINTS, pts);
        write_reg(CFG_PROFILE, prof);
        write_reg(CFG_SPARE, 16'($urandom));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Block is idle once everything queued was taken and all samples came back.
    task automatic wait_idle();
        while (pending_requests.size() > 0 || start || gap_left > 0 ||
               expected_samples.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic void queue_req(int s, int e);
        traj_req_t r;
        r.start_angle = 16'(s);
        r.end_angle   = 16'(e);
        pending_requests.insert(pending_requests.size(), r);
    endfunction

    function automatic void queue_random();
        int s, e;
        s = $urandom_range(0, 65535) - 32768;
        case ($urandom_range(0, 5))
            0: e = s;
            1: e = s + $urandom_range(0, 64) - 32;
            2: e = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
            default: e = $urandom_range(0, 65535) - 32768;
        endcase
        if (e > 32767)
            e = 32767;
        if (e < -32768)
            e = -32768;
        queue_req(s, e);
    endfunction

    initial begin
        logic [15:0] dur, pts;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: reset configuration, extremes of the angle range.
        queue_req(0, 0);
        queue_req(-32768, 32767);
        queue_req(32767, -32768);
        queue_req(0, 32767);
        queue_req(0, -32768);
        queue_req(100, -100);
        queue_req(-1, 1);
        wait_idle();

        // Quintic, short duration: velocity saturation both ways.
        configure(16'd1, 16'd64, 16'd1);
        queue_req(-32768, 32767);
        queue_req(32767, -32768);
        queue_req(5, 7);
        wait_idle();

        // Short run through zero and one, zero duration, long run clipped.
        configure(16'd0, 16'd0, 16'd0);
        queue_req(-32768, 32767);
        queue_req(1234, -4321);
        wait_idle();
        configure(16'd65535, 16'd1, 16'd1);
        queue_req(32767, -32768);
        wait_idle();
        configure(16'd65535, 16'h007F, 16'hFFFE);
        queue_req(-32768, 32767);
        queue_req(0, 1);
        wait_idle();
        configure(16'd0, 16'hFF80 | 16'd65, 16'd1);
        queue_req(32767, 0);
        wait_idle();

        // Random phases; mostly small runs, some long, varied durations.
        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 3))
                0: dur = 16'($urandom_range(0, 20));
                1: dur = 16'($urandom_range(60000, 65535));
                default: dur = 16'($urandom);
            endcase
            if ($urandom_range(0, 4) == 0)
                pts = 16'($urandom_range(0, 127));
            else
                pts = 16'($urandom_range(2, 12));
            pts[15:7] = 9'($urandom);
            steady = (ph % 4 == 3);
            configure(dur, pts, 16'($urandom));
            for (int k = 0; k < 21; k++)
                queue_random();
            wait_idle();
        end

        if (mismatches == 0 && expected_samples.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
src/jtts_pkg.sv
src/jtts_seq.sv
src/jtts_poly.sv
src/jtts_div.sv
src/joint_trajectory_time_scaling_unit.sv
dv/tb_joint_trajectory_time_scaling_unit.sv
